### rtl/rusi_pkg.sv
package rusi_pkg;

  // Q(31-F).F number format
  localparam int FracBits = 16;

  // square root of (disc << F): radicand width, padded to an even count
  localparam int SqXW    = 31 + FracBits;
  localparam int SqSteps = (SqXW + 1) / 2;
  localparam int SqXPW   = 2 * SqSteps;
  localparam int SqRemW  = SqSteps + 2;

  // root division: (|num| << F) / (2a)
  localparam int NumW = 34;
  localparam int MagW = 33;
  localparam int DenW = 33;
  localparam int DvW  = MagW + FracBits;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [31:0] disc;
    logic [31:0]        a;
    logic signed [31:0] b;
  } sq_side_t;

  typedef struct packed {
    logic [SqRemW-1:0]  rem;
    logic [SqSteps-1:0] root;
    logic [SqXPW-1:0]   xsh;
    sq_side_t           side;
  } sq_t;

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [DvW-1:0]  nq;   // dividend bits leave at the top, quotient bits enter at the bottom
  } dv_lane_t;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [31:0] disc;
    logic               hit;
    logic               azero;
    logic [1:0]         neg;   // [0] near, [1] far numerator sign
    logic [1:0]         nz;    // numerator nonzero
  } dv_side_t;

  typedef struct packed {
    logic [DenW-1:0] den;
    dv_lane_t        ln_near;
    dv_lane_t        ln_far;
    dv_side_t        side;
  } dv_t;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [31:0] disc;
    logic signed [31:0] far_t;
    logic signed [31:0] near_t;
    logic               hit;
  } res_t;

endpackage

### rtl/rusi_front.sv
module rusi_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [31:0]   origin_x_i,
  input  logic signed [31:0]   origin_y_i,
  input  logic signed [31:0]   origin_z_i,
  input  logic signed [31:0]   dir_x_i,
  input  logic signed [31:0]   dir_y_i,
  input  logic signed [31:0]   dir_z_i,
  input  logic [7:0]           object_id_i,
  output logic                 valid_o,
  output rusi_pkg::sq_t        sq_o
);
  import rusi_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] sx66(input logic signed [63:0] v);
    return {{2{v[63]}}, v};
  endfunction

  // stage 1: products
  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [63:0] pdd_q [3];
  logic signed [63:0] pdo_q [3];
  logic signed [63:0] poo_q [3];
  logic [7:0]         id1_q, id2_q, id3_q;

  // stage 2: a, b, c
  logic signed [31:0] a2_q, b2_q, c2_q;

  // stage 3: b*b, a*c
  logic signed [63:0] bb3_q, ac3_q;
  logic signed [31:0] a3_q, b3_q;

  logic signed [65:0] sdd, sdo, soo, cfull, tval;
  logic signed [31:0] disc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pdd_q[0] <= dir_x_i * dir_x_i;
      pdd_q[1] <= dir_y_i * dir_y_i;
      pdd_q[2] <= dir_z_i * dir_z_i;
      pdo_q[0] <= dir_x_i * origin_x_i;
      pdo_q[1] <= dir_y_i * origin_y_i;
      pdo_q[2] <= dir_z_i * origin_z_i;
      poo_q[0] <= origin_x_i * origin_x_i;
      poo_q[1] <= origin_y_i * origin_y_i;
      poo_q[2] <= origin_z_i * origin_z_i;
      id1_q    <= object_id_i;
    end
  end

  always_comb begin
    sdd   = sx66(pdd_q[0]) + sx66(pdd_q[1]) + sx66(pdd_q[2]);
    sdo   = sx66(pdo_q[0]) + sx66(pdo_q[1]) + sx66(pdo_q[2]);
    soo   = sx66(poo_q[0]) + sx66(poo_q[1]) + sx66(poo_q[2]);
    cfull = (soo >>> FracBits) - (66'sd1 <<< FracBits);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a2_q  <= sat32(sdd >>> FracBits);
      b2_q  <= sat32(sdo >>> (FracBits - 1));
      c2_q  <= sat32(cfull);
      id2_q <= id1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb3_q <= b2_q * b2_q;
      ac3_q <= a2_q * c2_q;
      a3_q  <= a2_q;
      b3_q  <= b2_q;
      id3_q <= id2_q;
    end
  end

  // b*b - 4ac over 2^F equals floor(((bb >> 2) - ac) / 2^(F-2))
  always_comb begin
    tval = $signed({4'b0000, bb3_q[63:2]}) - sx66(ac3_q);
    disc = sat32(tval >>> (FracBits - 2));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_o.rem       <= '0;
      sq_o.root      <= '0;
      sq_o.xsh       <= SqXPW'({disc[30:0], {FracBits{1'b0}}});
      sq_o.side.id   <= id3_q;
      sq_o.side.disc <= disc;
      sq_o.side.a    <= a3_q;
      sq_o.side.b    <= b3_q;
    end
  end

  assign valid_o = v4_q;

endmodule

### rtl/rusi_sqrt_cell.sv
module rusi_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rusi_pkg::sq_t cell_i,
  output logic          valid_o,
  output rusi_pkg::sq_t cell_o
);
  import rusi_pkg::*;

  logic [SqRemW+1:0] cand, trial, diff;
  logic              ge;
  sq_t               cell_d;

  // one root bit per cell: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    cand  = {cell_i.rem, cell_i.xsh[SqXPW-1 -: 2]};
    trial = {2'b00, cell_i.root, 2'b01};
    ge    = cand >= trial;
    diff  = cand - trial;
    cell_d      = cell_i;
    cell_d.rem  = ge ? diff[SqRemW-1:0] : cand[SqRemW-1:0];
    cell_d.root = {cell_i.root[SqSteps-2:0], ge};
    cell_d.xsh  = {cell_i.xsh[SqXPW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= cell_d;
    end
  end

endmodule

### rtl/rusi_div_cell.sv
module rusi_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rusi_pkg::dv_t cell_i,
  output logic          valid_o,
  output rusi_pkg::dv_t cell_o
);
  import rusi_pkg::*;

  function automatic dv_lane_t div_step(input dv_lane_t ln, input logic [DenW-1:0] den);
    logic [DenW:0] cand;
    logic [DenW:0] diff;
    logic          ge;
    dv_lane_t      r;
    cand  = {ln.rem, ln.nq[DvW-1]};
    ge    = cand >= {1'b0, den};
    diff  = cand - {1'b0, den};
    r.rem = ge ? diff[DenW-1:0] : cand[DenW-1:0];
    r.nq  = {ln.nq[DvW-2:0], ge};
    return r;
  endfunction

  dv_t cell_d;

  // one quotient bit per cell for both roots
  always_comb begin
    cell_d         = cell_i;
    cell_d.ln_near = div_step(cell_i.ln_near, cell_i.den);
    cell_d.ln_far  = div_step(cell_i.ln_far, cell_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= cell_d;
    end
  end

endmodule

### rtl/ray_unit_sphere_intersection_top.sv
// Pipeline: 4 front stages + SqSteps square root cells + 1 setup stage + DvW division
//   cells + 1 output register; with 16 fraction bits the counts are 4 + 24 + 1 + 49 + 1.
// Throughput: one ray per cycle while the skid register is empty; each stage holds one word.
// A stalled output parks one word in a skid register; the pipeline holds while it is full.
// Reset clears every valid bit, those of the output and skid registers included; the
// data registers, output and skid data among them, are not reset.
module ray_unit_sphere_intersection_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [191:0]  s_axis_tdata_i,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [7:0]    s_axis_tuser_i,   // object_id
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [95:0]   m_axis_tdata_o,   // near_t, far_t, discriminant
  output logic [8:0]    m_axis_tuser_o    // hit, hit_object
);
  import rusi_pkg::*;

  // Resolve one root from the quotient magnitude, saturating to 32 bits.
  function automatic logic signed [31:0] root_fin(input logic nz, input logic neg,
                                                  input logic azero,
                                                  input logic [DvW-1:0] q);
    logic [DvW-1:0] lim;
    lim = DvW'(33'h0_8000_0000);
    if (!nz) return '0;
    if (azero) return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    if (neg) return (q > lim) ? 32'sh8000_0000 : (~q[31:0] + 32'd1);
    return (q >= lim) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  logic pipe_en;

  // front: dot products, a/b/c, discriminant
  logic sq_v [SqSteps+1];
  sq_t  sq_q [SqSteps+1];

  rusi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (s_axis_tvalid_i),
    .origin_x_i  (s_axis_tdata_i[31:0]),
    .origin_y_i  (s_axis_tdata_i[63:32]),
    .origin_z_i  (s_axis_tdata_i[95:64]),
    .dir_x_i     (s_axis_tdata_i[127:96]),
    .dir_y_i     (s_axis_tdata_i[159:128]),
    .dir_z_i     (s_axis_tdata_i[191:160]),
    .object_id_i (s_axis_tuser_i),
    .valid_o     (sq_v[0]),
    .sq_o        (sq_q[0])
  );

  // square root row: one result bit per cell
  for (genvar i = 0; i < SqSteps; i++) begin : g_sqrt
    rusi_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (sq_v[i]),
      .cell_i  (sq_q[i]),
      .valid_o (sq_v[i+1]),
      .cell_o  (sq_q[i+1])
    );
  end

  // setup: numerators -b -/+ s, their signs and magnitudes, divisor 2a
  logic                   dv_v [DvW+1];
  dv_t                    dv_q [DvW+1];
  sq_t                    sq_end;
  logic signed [NumW-1:0] bx, sx, num_n, num_f, mag_n, mag_f;
  dv_t                    prep_d;

  always_comb begin
    sq_end = sq_q[SqSteps];
    bx     = {{(NumW-32){sq_end.side.b[31]}}, sq_end.side.b};
    sx     = $signed(NumW'(sq_end.root));
    num_n  = -bx - sx;
    num_f  = -bx + sx;
    mag_n  = num_n[NumW-1] ? -num_n : num_n;
    mag_f  = num_f[NumW-1] ? -num_f : num_f;

    prep_d.den            = {sq_end.side.a, 1'b0};
    prep_d.ln_near.rem    = '0;
    prep_d.ln_near.nq     = {mag_n[MagW-1:0], {FracBits{1'b0}}};
    prep_d.ln_far.rem     = '0;
    prep_d.ln_far.nq      = {mag_f[MagW-1:0], {FracBits{1'b0}}};
    prep_d.side.id        = sq_end.side.id;
    prep_d.side.disc      = sq_end.side.disc;
    prep_d.side.hit       = !sq_end.side.disc[31] && (sq_end.side.disc != '0);
    prep_d.side.azero     = (sq_end.side.a == '0);
    prep_d.side.neg       = {num_f[NumW-1], num_n[NumW-1]};
    prep_d.side.nz        = {num_f != '0, num_n != '0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (pipe_en) begin
      dv_v[0] <= sq_v[SqSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dv_q[0] <= prep_d;
    end
  end

  // division row: one quotient bit per cell, both roots side by side
  for (genvar j = 0; j < DvW; j++) begin : g_div
    rusi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (dv_v[j]),
      .cell_i  (dv_q[j]),
      .valid_o (dv_v[j+1]),
      .cell_o  (dv_q[j+1])
    );
  end

  // finish: saturate the roots, zero them on a miss
  dv_t  dv_end;
  res_t res_d;

  always_comb begin
    dv_end       = dv_q[DvW];
    res_d.hit    = dv_end.side.hit;
    res_d.id     = dv_end.side.id;
    res_d.disc   = dv_end.side.disc;
    res_d.near_t = dv_end.side.hit ?
                   root_fin(dv_end.side.nz[0], dv_end.side.neg[0], dv_end.side.azero,
                            dv_end.ln_near.nq) : '0;
    res_d.far_t  = dv_end.side.hit ?
                   root_fin(dv_end.side.nz[1], dv_end.side.neg[1], dv_end.side.azero,
                            dv_end.ln_far.nq) : '0;
  end

  // output register plus skid register
  logic out_v_q, skid_v_q;
  res_t out_q, skid_q;
  logic load_out, arrive;

  assign pipe_en  = !skid_v_q;
  assign load_out = !out_v_q || m_axis_tready_i;
  assign arrive   = dv_v[DvW] && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_out) begin
      // drain the skid word first; the pipeline is held while it is full
      out_v_q  <= skid_v_q || arrive;
      skid_v_q <= 1'b0;
    end else if (arrive) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (arrive) begin
      skid_q <= res_d;
    end
  end

  assign s_axis_tready_o = pipe_en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.disc, out_q.far_t, out_q.near_t};
  assign m_axis_tuser_o  = {out_q.id, out_q.hit};

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held while output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready_i))
    else $error("skid register filled without an output stall");

  a_hit_matches_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.hit == (!out_q.disc[31] && out_q.disc != '0)))
    else $error("hit flag disagrees with discriminant sign");

  a_miss_zero_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.hit) |-> (out_q.near_t == '0 && out_q.far_t == '0))
    else $error("roots nonzero on a miss");
`endif

endmodule

### tb/ray_unit_sphere_intersection_top_test.sv
`timescale 1ns / 100ps

module ray_unit_sphere_intersection_top_test;
  import rusi_pkg::*;

  localparam int  FB        = FracBits;
  localparam int  IdleLimit = 20000;
  localparam int  Q_ONE     = 1 << FB;

  typedef logic signed [127:0] wide_t;

  // one ray as it enters the block
  typedef struct packed {
    logic [7:0]         id;
    logic signed [31:0] dz;
    logic signed [31:0] dy;
    logic signed [31:0] dx;
    logic signed [31:0] oz;
    logic signed [31:0] oy;
    logic signed [31:0] ox;
  } ray_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [191:0] s_axis_tdata_i = '0;
  logic [7:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [95:0]  m_axis_tdata_o;
  logic [8:0]   m_axis_tuser_o;

  res_t hit_queue[$];   // predicted intersections, oldest first
  int   n_fail = 0;
  int   idle_cycles = 0;
  int   hold_off = 0;    // receiver holds off while this counts down
  int   burst_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  ray_unit_sphere_intersection_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    .s_axis_tuser_i  (s_axis_tuser_i),   // object_id
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // near_t, far_t, discriminant
    .m_axis_tuser_o  (m_axis_tuser_o)    // hit, hit_object
  );

  function automatic wide_t clamp32(wide_t x);
    if (x > 128'sd2147483647) return 128'sd2147483647;
    if (x < -128'sd2147483648) return -128'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // root = num * 2^F / den, truncated toward zero; zero or negative den pins to the rails
  function automatic logic signed [31:0] root_quot(wide_t num, wide_t den);
    wide_t mag, q;
    if (num == 0) return '0;
    if (den <= 0) return (num < 0) ? 32'sh8000_0000 : 32'sh7fff_ffff;
    mag = (num < 0) ? -num : num;
    q   = (mag <<< FB) / den;
    if (q > (128'sd1 <<< 40)) q = 128'sd1 <<< 40;
    q = clamp32((num < 0) ? -q : q);
    return q[31:0];
  endfunction

  function automatic res_t intersect_sphere(ray_t r);
    wide_t ox, oy, oz, dx, dy, dz, a, b, c, t, disc, s;
    res_t  e;
    ox = r.ox; oy = r.oy; oz = r.oz;
    dx = r.dx; dy = r.dy; dz = r.dz;
    a    = clamp32((dx * dx + dy * dy + dz * dz) >>> FB);
    b    = clamp32((dx * ox + dy * oy + dz * oz) >>> (FB - 1));
    c    = clamp32(((ox * ox + oy * oy + oz * oz) >>> FB) - Q_ONE);
    t    = ((b * b) >>> 2) - a * c;
    disc = clamp32(t >>> (FB - 2));
    e = '0;
    e.id   = r.id;
    e.disc = disc[31:0];
    if (disc > 0) begin
      s = {64'd0, int_sqrt(64'(disc) << FB)};
      e.hit    = 1'b1;
      e.near_t = root_quot(-b - s, 2 * a);
      e.far_t  = root_quot(-b + s, 2 * a);
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    n_fail++;
  endtask

  // offer one ray; return right after the edge that takes it, with tvalid still high
  task automatic send_ray(ray_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
    s_axis_tuser_i  <= r.id;
    do @(posedge clk_i); while (!s_axis_tready_o);
    hit_queue.push_back(intersect_sphere(r));
  endtask

  task automatic go_idle();
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    go_idle();
    while (hit_queue.size() != 0) @(posedge clk_i);
  endtask

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz, int id);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dx; r.dy = dy; r.dz = dz;
    r.id = id[7:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom();                             // any bit pattern
      1:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2:       return $urandom_range(0, 1023) - 512;          // tiny
      default: return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE; // within +/-4.0
    endcase
  endfunction

  task automatic test_directed();
    send_ray(make_ray(0, 0, -3 * Q_ONE, 0, 0, Q_ONE, 0));          // plain hit
    send_ray(make_ray(0, 0, 0, Q_ONE, 0, 0, 255));                 // from inside
    send_ray(make_ray(0, Q_ONE, 0, Q_ONE, 0, 0, 1));               // tangent, no hit
    send_ray(make_ray(0, 2 * Q_ONE, 0, Q_ONE, 0, 0, 2));           // clean miss
    send_ray(make_ray(1 << 30, 0, 0, 1, 0, 0, 3));                 // hit with zero a
    send_ray(make_ray(-(1 << 30), 0, 0, 1, 0, 0, 4));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 5));                       // zero direction
    send_ray(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 6));
    send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000, 7));
    send_ray(make_ray(32'h80000000, 32'h7fffffff, 32'h80000000,
                      32'h7fffffff, 32'h80000000, 32'h7fffffff, 8));
    send_ray(make_ray(0, 0, 0, 32'h7fffffff, 0, 0, 9));            // saturated a
    send_ray(make_ray(1 << 28, 1 << 28, 0, 1 << 20, 1 << 20, 0, 10)); // saturated discriminant
    send_ray(make_ray(0, 0, 5 * Q_ONE, 0, 0, Q_ONE, 11));          // sphere behind origin
    send_ray(make_ray(Q_ONE / 2, 0, -Q_ONE * 2, 0, 3, 5, 12));     // tiny direction
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_ray(make_ray(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 255)));
  endtask

  // hold the output long enough that the pipeline fills and input stalls
  task automatic test_backpressure();
    hold_off = 400;
    test_random(200);
    wait_drained();
  endtask

  // receiver: stall on one of four patterns, redrawn at random as rx_phase counts up
  int rx_mode = 0;
  int rx_phase = 0;
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 64 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_off > 0) begin
      hold_off        <= hold_off - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= $urandom_range(0, 1);
        2:       m_axis_tready_i <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready_i <= ((rx_phase / 5) % 2 == 0);
      endcase
    end
  end

  // check each result word against the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (hit_queue.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        n_fail++;
      end else begin
        want = hit_queue.pop_front();
        if (m_axis_tuser_o[0] !== want.hit)
          report_mismatch("hit", m_axis_tuser_o[0], want.hit);
        if (m_axis_tuser_o[8:1] !== want.id)
          report_mismatch("hit_object", m_axis_tuser_o[8:1], want.id);
        if (m_axis_tdata_o[31:0] !== want.near_t)
          report_mismatch("near_t", m_axis_tdata_o[31:0], want.near_t);
        if (m_axis_tdata_o[63:32] !== want.far_t)
          report_mismatch("far_t", m_axis_tdata_o[63:32], want.far_t);
        if (m_axis_tdata_o[95:64] !== want.disc)
          report_mismatch("discriminant", m_axis_tdata_o[95:64], want.disc);
      end
    end
  end

  // watchdog: count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    test_backpressure();
    test_random(436);
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
